@@ hdl/deba_pkg.sv @@
// Shared types and constants for the double-ended bump allocator.
package deba_pkg;

  localparam int ADDR_W_DEF = 24;   // default pointer/address width
  localparam int FIELD_W    = 24;   // width of the size and address fields
  localparam int CFG_IDX_W  = 2;
  localparam int LOG2_W     = 4;
  localparam int MASK_W     = 16;   // alignment mask, up to 2^15 - 1
  localparam int MIN_UNIT   = 4;
  localparam int MIN_LOG2   = 2;

  typedef enum logic [1:0] {
    FUNC_ALLOC     = 2'd0,
    FUNC_FREE_TAIL = 2'd1,
    FUNC_FREE_ALL  = 2'd2,
    FUNC_CHECK     = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_START   = 2'd0,
    REG_HEAP_SIZE    = 2'd1,
    REG_ERROR_REPORT = 2'd2
  } cfg_reg_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic capture;    // latch an incoming item
    logic size_step;  // round size, align head, region end
    logic plan_step;  // tail start, head need, accounting sum
    logic commit;     // update pointers and load the result
  } cmd_t;

endpackage

@@ hdl/deba_ctrl.sv @@
// Sequencer for the allocator: steps one item through size, plan and commit.
module deba_ctrl
  import deba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SIZE = 4'b0010,
    S_PLAN = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // result slot can take a new item if empty or being drained this cycle
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.size_step = 1'b0;
    cmd.plan_step = 1'b0;
    cmd.commit    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SIZE;
        end
      end
      S_SIZE: begin
        cmd.size_step = 1'b1;
        state_next    = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan_step = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/deba_dp.sv @@
// Datapath: configuration registers, arena pointers and result register.
module deba_dp
  import deba_pkg::*;
#(
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic [1:0]           func,
  input  logic [FIELD_W-1:0]   req_size,
  input  logic                 from_tail,
  input  logic [LOG2_W-1:0]    align_log2,
  output logic [FIELD_W-1:0]   address,
  output logic                 ok,
  output logic                 error_event,
  output logic [FIELD_W-1:0]   free_bytes
);

  localparam int PW = ADDR_W + 1;                                  // pointer width
  localparam int EW = ((ADDR_W > FIELD_W) ? ADDR_W : FIELD_W) + 3; // no-wrap width
  localparam int CW = ADDR_W + 4;                                  // accounting sum
  localparam int RW = FIELD_W + 1;                                 // rounded size

  // configuration
  logic [ADDR_W-1:0] heap_start;
  logic [ADDR_W-1:0] heap_size;
  logic              error_report;

  // arena state
  logic [PW-1:0]     head_ptr;
  logic [PW-1:0]     tail_ptr;
  logic [ADDR_W-1:0] free_count;

  // captured item
  func_t              func_q;
  logic [FIELD_W-1:0] size_q;
  logic               tail_q;
  logic [LOG2_W-1:0]  lg_q;

  // intermediate registers
  logic [MASK_W-1:0] amask_r;
  logic [EW-1:0]     rsize_r;
  logic [EW-1:0]     hstart_r;
  logic [PW-1:0]     end_r;
  logic [CW-1:0]     chk_r;
  logic [EW-1:0]     tstart_r;
  logic [EW-1:0]     hneed_r;
  logic              tail_fit_r;

  // size stage logic
  logic [LOG2_W-1:0]  lg_eff;
  logic [MASK_W-1:0]  amask;
  logic [FIELD_W-1:0] size_min;
  logic [RW-1:0]      rsize;
  logic [EW-1:0]      hstart;

  // commit logic
  logic [EW-1:0]     tneed;
  logic [EW-1:0]     need;
  logic              fits;
  logic [EW-1:0]     blk_start;
  logic [ADDR_W-1:0] free_next;
  logic [PW-1:0]     head_next;
  logic [PW-1:0]     tail_next;
  logic [FIELD_W-1:0] addr_next;
  logic              ok_next;
  logic              err_next;

  always_comb begin
    lg_eff   = (lg_q < LOG2_W'(MIN_LOG2)) ? LOG2_W'(MIN_LOG2) : lg_q;
    amask    = (MASK_W'(1) << lg_eff) - MASK_W'(1);
    size_min = (size_q < FIELD_W'(MIN_UNIT)) ? FIELD_W'(MIN_UNIT) : size_q;
    rsize    = (RW'(size_min) + RW'(amask)) & ~RW'(amask);
    hstart   = (EW'(head_ptr) + EW'(amask)) & ~EW'(amask);
  end

  always_comb begin
    tneed     = EW'(tail_ptr) - tstart_r;
    need      = tail_q ? tneed : hneed_r;
    fits      = (need <= EW'(free_count)) && (!tail_q || tail_fit_r);
    blk_start = tail_q ? tstart_r : hstart_r;
    free_next = free_count;
    head_next = head_ptr;
    tail_next = tail_ptr;
    addr_next = '0;
    ok_next   = 1'b1;
    err_next  = 1'b0;
    case (func_q)
      FUNC_ALLOC: begin
        if (fits) begin
          free_next = free_count - ADDR_W'(need);
          addr_next = FIELD_W'(ADDR_W'(blk_start));
          if (tail_q) begin
            tail_next = PW'(tstart_r);
          end else begin
            head_next = PW'(EW'(head_ptr) + need);
          end
        end else begin
          ok_next  = 1'b0;
          err_next = error_report;
        end
      end
      FUNC_FREE_TAIL: begin
        free_next = free_count + ADDR_W'(end_r) - ADDR_W'(tail_ptr);
        tail_next = end_r;
      end
      FUNC_FREE_ALL: begin
        free_next = heap_size;
        head_next = PW'(heap_start);
        tail_next = end_r;
      end
      FUNC_CHECK: begin
        ok_next = (chk_r == CW'(heap_size));
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start   <= '0;
      heap_size    <= '0;
      error_report <= 1'b0;
      head_ptr     <= '0;
      tail_ptr     <= '0;
      free_count   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HEAP_START:   heap_start   <= ADDR_W'(cfg_data);
          REG_HEAP_SIZE:    heap_size    <= ADDR_W'(cfg_data);
          REG_ERROR_REPORT: error_report <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        head_ptr   <= head_next;
        tail_ptr   <= tail_next;
        free_count <= free_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func_t'(func);
      size_q <= req_size;
      tail_q <= from_tail;
      lg_q   <= align_log2;
    end
    if (cmd.size_step) begin
      amask_r  <= amask;
      rsize_r  <= EW'(rsize);
      hstart_r <= hstart;
      end_r    <= PW'(heap_start) + PW'(heap_size);
      chk_r    <= CW'(free_count) + CW'(head_ptr) - CW'(heap_start);
    end
    if (cmd.plan_step) begin
      tail_fit_r <= (rsize_r <= EW'(tail_ptr));
      tstart_r   <= (EW'(tail_ptr) - rsize_r) & ~EW'(amask_r);
      hneed_r    <= hstart_r - EW'(head_ptr) + rsize_r;
      chk_r      <= chk_r + CW'(end_r) - CW'(tail_ptr);
    end
    if (cmd.commit) begin
      address     <= addr_next;
      ok          <= ok_next;
      error_event <= err_next;
      free_bytes  <= FIELD_W'(free_next);
    end
  end

endmodule

@@ hdl/double_ended_bump_allocator.sv @@
// Result: registered at commit, after the item steps through the size and
// plan states; commit waits in the exec state while the result is stalled.
// Throughput: one item at a time through the shared datapath; a finished
// result waits in the output register while the next item is taken.
// Reset: pointers, free count and configuration registers clear to zero; issue free_all
// after configuration to load the arena.
module double_ended_bump_allocator
  import deba_pkg::*;
#(
  parameter int ADDR_W = ADDR_W_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [FIELD_W-1:0]   req_size,
  input  logic                 from_tail,
  input  logic [LOG2_W-1:0]    align_log2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   address,
  output logic                 ok,
  output logic                 error_event,
  output logic [FIELD_W-1:0]   free_bytes
);

  cmd_t cmd;

  deba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  deba_dp #(
    .ADDR_W (ADDR_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .req_size    (req_size),
    .from_tail   (from_tail),
    .align_log2  (align_log2),
    .address     (address),
    .ok          (ok),
    .error_event (error_event),
    .free_bytes  (free_bytes)
  );

endmodule

@@ dv/double_ended_bump_allocator_test.sv @@
// Self-checking testbench for the double-ended bump allocator: scoreboarded requests and stalls.
module double_ended_bump_allocator_test;
  import deba_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] address;
    logic               ok;
    logic               error_event;
    logic [FIELD_W-1:0] free_bytes;
  } outcome_t;

  // Tracks the arena as the block should see it and holds the outcomes still owed.
  class arena_tracker;
    localparam bit [63:0] ADDR_MASK = (64'd1 << ADDR_W_DEF) - 1;
    localparam bit [63:0] PTR_MASK  = (64'd1 << (ADDR_W_DEF + 1)) - 1;

    bit [63:0] base, span, report;
    bit [63:0] head, tail, avail;
    outcome_t  predicted[$];
    int        mismatches;

    function void write_reg(cfg_reg_t idx, bit [FIELD_W-1:0] val);
      case (idx)
        REG_HEAP_START:   base = val;
        REG_HEAP_SIZE:    span = val;
        REG_ERROR_REPORT: report = val[0];
        default: ;
      endcase
    endfunction

    // end may sit one past the top of the address space, hence the wider mask
    function bit [63:0] arena_end();
      return (base + span) & PTR_MASK;
    endfunction

    function void take_request(func_t f, bit [FIELD_W-1:0] sz, bit at_tail,
                               bit [LOG2_W-1:0] lg);
      bit [63:0] amask, rounded, start, need, total;
      bit        fits;
      outcome_t  o;
      o = '0;
      o.ok = 1'b1;
      case (f)
        FUNC_ALLOC: begin
          fits = 1'b0;
          amask = (64'd1 << ((lg < MIN_LOG2) ? MIN_LOG2 : lg)) - 1;
          rounded = (sz < MIN_UNIT) ? MIN_UNIT : sz;
          rounded = (rounded + amask) & ~amask;
          if (!at_tail) begin
            start = (head + amask) & ~amask;
            need = (start - head) + rounded;
            if (need <= avail) begin
              fits = 1'b1;
              o.address = start[FIELD_W-1:0];
              head = (head + need) & PTR_MASK;
            end
          end else if (rounded <= tail) begin
            start = (tail - rounded) & ~amask;
            need = tail - start;
            if (need <= avail) begin
              fits = 1'b1;
              o.address = start[FIELD_W-1:0];
              tail = start;
            end
          end
          if (fits) begin
            avail = (avail - need) & ADDR_MASK;
          end else begin
            o.ok = 1'b0;
            o.address = '0;
            o.error_event = report[0];
          end
        end
        FUNC_FREE_TAIL: begin
          avail = (avail + arena_end() - tail) & ADDR_MASK;
          tail = arena_end();
        end
        FUNC_FREE_ALL: begin
          avail = span;
          head = base;
          tail = arena_end();
        end
        default: begin
          total = avail + (head - base) + (arena_end() - tail);
          o.ok = (total == span);
        end
      endcase
      o.free_bytes = avail[FIELD_W-1:0];
      predicted.push_back(o);
    endfunction

    function void match_outcome(outcome_t got);
      outcome_t exp;
      if (predicted.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: addr %h ok %b err %b free %h",
                   $time, got.address, got.ok, got.error_event, got.free_bytes);
        return;
      end
      exp = predicted.pop_front();
      if (got.address !== exp.address || got.ok !== exp.ok ||
          got.error_event !== exp.error_event || got.free_bytes !== exp.free_bytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp addr %h ok %b err %b free %h / got addr %h ok %b err %b free %h",
                   $time, exp.address, exp.ok, exp.error_event, exp.free_bytes,
                   got.address, got.ok, got.error_event, got.free_bytes);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  cfg_reg_t           cfg_index = REG_HEAP_START;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  func_t              func = FUNC_ALLOC;
  logic [FIELD_W-1:0] req_size = '0;
  logic               from_tail = 1'b0;
  logic [LOG2_W-1:0]  align_log2 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] address;
  logic               ok;
  logic               error_event;
  logic [FIELD_W-1:0] free_bytes;

  arena_tracker arena = new();
  int sender_gaps = 0;   // percent chance of a gap before an item
  int stall_pct = 0;     // percent chance of starting a stall burst
  int stall_left = 0;

  double_ended_bump_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .req_size(req_size), .from_tail(from_tail), .align_log2(align_log2),
    .out_valid(out_valid), .out_stall(out_stall),
    .address(address), .ok(ok), .error_event(error_event), .free_bytes(free_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both sides are observed at the same edge, inputs first.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) arena.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) arena.take_request(func, req_size, from_tail, align_log2);
      if (out_valid && !out_stall) arena.match_outcome({address, ok, error_event, free_bytes});
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(func_t f, bit [FIELD_W-1:0] sz, bit at_tail, bit [LOG2_W-1:0] lg);
    if (sender_gaps != 0 && $urandom_range(0, 99) < sender_gaps) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    req_size <= sz;
    from_tail <= at_tail;
    align_log2 <= lg;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (arena.predicted.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(cfg_reg_t idx, bit [FIELD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // upper bits of the error_report word are sometimes junk; only bit 0 counts
  task automatic load_regs(bit [FIELD_W-1:0] s, bit [FIELD_W-1:0] n, bit rep);
    bit [FIELD_W-1:0] rep_word;
    rep_word = {($urandom_range(0, 1) ? 23'($urandom()) : 23'd0), rep};
    put_reg(REG_HEAP_START, s);
    put_reg(REG_HEAP_SIZE, n);
    put_reg(REG_ERROR_REPORT, rep_word);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_region();
    bit [FIELD_W-1:0] s, n;
    case ($urandom_range(0, 5))
      0: begin s = FIELD_W'($urandom()); n = FIELD_W'($urandom_range(0, 512)); end
      1: begin s = FIELD_W'($urandom()); n = FIELD_W'($urandom_range(512, 65536)); end
      2: begin s = FIELD_W'($urandom()); n = FIELD_W'($urandom()); end
      3: begin s = '0; n = '1; end
      4: begin s = '1; n = '1; end
      default: begin s = '0; n = '0; end
    endcase
    load_regs(s, n, 1'($urandom_range(0, 1)));
    // now and then skip the reload so stale pointers meet new registers
    if ($urandom_range(0, 4) != 0)
      send(FUNC_FREE_ALL, FIELD_W'($urandom()), 1'($urandom_range(0, 1)),
           LOG2_W'($urandom_range(0, 15)));
  endtask

  task automatic random_item();
    int               r;
    bit [FIELD_W-1:0] sz;
    bit [LOG2_W-1:0]  lg;
    func_t            f;
    r = $urandom_range(0, 99);
    if (r < 72)      f = FUNC_ALLOC;
    else if (r < 80) f = FUNC_FREE_TAIL;
    else if (r < 86) f = FUNC_FREE_ALL;
    else             f = FUNC_CHECK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: sz = FIELD_W'($urandom_range(0, 64));
      5, 6:          sz = FIELD_W'($urandom_range(0, 4096));
      7:             sz = FIELD_W'($urandom_range(0, arena.span[31:0] >> 2));
      8:             sz = arena.avail[FIELD_W-1:0];   // try to fill what is left
      default:       sz = FIELD_W'($urandom());
    endcase
    lg = ($urandom_range(0, 99) < 80) ? LOG2_W'($urandom_range(0, 6))
                                      : LOG2_W'($urandom_range(0, 15));
    send(f, sz, 1'($urandom_range(0, 1)), lg);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // arena never loaded: allocations fail, quietly then loudly
    send(FUNC_ALLOC, 24'd0, 1'b0, 4'd0);
    send(FUNC_ALLOC, 24'd16, 1'b1, 4'd3);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    settle();
    load_regs(24'd0, 24'd0, 1'b1);
    send(FUNC_ALLOC, 24'd8, 1'b0, 4'd2);
    settle();

    // unaligned start, minimum sizes, largest size and alignment
    load_regs(24'h000103, 24'h000400, 1'b1);
    send(FUNC_FREE_ALL, 24'd0, 1'b0, 4'd0);
    send(FUNC_ALLOC, 24'd0, 1'b0, 4'd0);
    send(FUNC_ALLOC, 24'd1, 1'b0, 4'd1);
    send(FUNC_ALLOC, 24'd5, 1'b0, 4'd4);
    send(FUNC_ALLOC, 24'hFFFFFF, 1'b0, 4'd15);
    send(FUNC_ALLOC, 24'd3, 1'b1, 4'd0);
    send(FUNC_ALLOC, 24'd100, 1'b1, 4'd6);
    send(FUNC_ALLOC, 24'h8000, 1'b1, 4'd15);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    send(FUNC_FREE_TAIL, 24'd0, 1'b0, 4'd0);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    settle();

    // tail pointer smaller than the request, then an exact fit
    load_regs(24'd0, 24'd64, 1'b0);
    send(FUNC_FREE_ALL, 24'd0, 1'b0, 4'd0);
    send(FUNC_ALLOC, 24'd128, 1'b1, 4'd2);
    send(FUNC_ALLOC, 24'd64, 1'b1, 4'd2);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    settle();

    // registers moved without a reload
    load_regs(24'h000800, 24'h000200, 1'b1);
    send(FUNC_FREE_TAIL, 24'd0, 1'b0, 4'd0);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    settle();

    // region running past the top of the address space
    load_regs(24'hFFFF00, 24'hFFFFFF, 1'b1);
    send(FUNC_FREE_ALL, 24'd0, 1'b0, 4'd0);
    send(FUNC_ALLOC, 24'h000200, 1'b0, 4'd8);
    send(FUNC_ALLOC, 24'd16, 1'b1, 4'd15);
    send(FUNC_ALLOC, 24'h001000, 1'b0, 4'd12);
    send(FUNC_CHECK, 24'd0, 1'b0, 4'd0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 2))
        0:       sender_gaps = 0;
        1:       sender_gaps = 25;
        default: sender_gaps = 60;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
      pick_region();
      repeat (62) random_item();
      settle();
    end

    // last stretch at full rate
    sender_gaps = 0;
    stall_pct = 0;
    pick_region();
    repeat (80) random_item();
    settle();

    if (arena.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
